// ===== hdl/uccd_pkg.sv =====
// Shared types, codes and divider constants for the millisecond clock with civil date.
package uccd_pkg;

    localparam int TICK_BITS = 32;
    localparam int MS_W      = 42;
    localparam int DVS_W     = 18;
    localparam int CNT_W     = 2;

    localparam logic [CNT_W-1:0] DIV_STEPS = 2'd3;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_CONVERT = 2'd2;

    localparam logic [19:0] DAYS_OFFSET = 20'd719468;
    localparam logic [17:0] LAST_DOE    = 18'd146096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MS,
        ST_GO,
        ST_WAIT,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        DV_MSH,
        DV_MS,
        DV_SEC,
        DV_MIN,
        DV_HOUR,
        DV_ERA,
        DV_C4,
        DV_C100,
        DV_YOE,
        DV_Y100,
        DV_MP,
        DV_DAY
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     calc_ms;
        logic     div_start;
        t_div_sel div_sel;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [DVS_W-1:0] div_divisor(input t_div_sel sel);
        logic [DVS_W-1:0] d;
        unique case (sel)
            DV_MSH:  d = 18'd1000;
            DV_MS:   d = 18'd1000;
            DV_SEC:  d = 18'd60;
            DV_MIN:  d = 18'd60;
            DV_HOUR: d = 18'd24;
            DV_ERA:  d = 18'd146097;
            DV_C4:   d = 18'd1460;
            DV_C100: d = 18'd36524;
            DV_YOE:  d = 18'd365;
            DV_Y100: d = 18'd100;
            DV_MP:   d = 18'd153;
            DV_DAY:  d = 18'd5;
            default: d = 18'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor): the quotient estimate is low by at most one
    function automatic logic [31:0] div_recip(input t_div_sel sel);
        logic [31:0] m;
        unique case (sel)
            DV_MSH:  m = 32'd4294967;
            DV_MS:   m = 32'd4294967;
            DV_SEC:  m = 32'd71582788;
            DV_MIN:  m = 32'd71582788;
            DV_HOUR: m = 32'd178956970;
            DV_ERA:  m = 32'd29398;
            DV_C4:   m = 32'd2941758;
            DV_C100: m = 32'd117593;
            DV_YOE:  m = 32'd11767033;
            DV_Y100: m = 32'd42949672;
            DV_MP:   m = 32'd28071681;
            DV_DAY:  m = 32'd858993459;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/unix_clock_with_civil_date_unit.sv =====
// Top level of the millisecond clock with UTC civil date breakdown.
// Each transfer in gives one transfer out once it has passed through these steps:
// the millisecond time, then twelve divisions by constants on a
// shared divider (load, reciprocal multiply, back-multiply and one correction
// step), and a final step that fills the output register. The input is ready
// again in the cycle after the output register is filled, so a new transfer is
// taken only once the last one is through; a stalled output holds the final step.
// A new transfer is taken while the previous result still waits on the output side.
module unix_clock_with_civil_date_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,  // operation[1:0], unix_seconds[33:2], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // synced, time_millis, whole_seconds, milli_part,
                                   // year, month, day, hour, minute, second, zero pad
);
    import uccd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    uccd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    uccd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_op       (s_tdata[1:0]),
        .i_secs     (s_tdata[33:2]),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/uccd_ctrl.sv =====
// Sequencer: accepts an item, then walks the divider through the date breakdown.
module uccd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  uccd_pkg::t_dp_stat i_stat,
    output uccd_pkg::t_dp_cmd  o_cmd
);
    import uccd_pkg::*;

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= DV_MSH;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            ST_IDLE: if (i_s_tvalid) n_state = ST_MS;
            ST_MS: begin
                n_state = ST_GO;
                n_sel   = DV_MSH;
            end
            ST_GO:   n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_stat.div_last) begin
                    if (r_sel == DV_DAY) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_GO;
                        n_sel   = t_div_sel'(r_sel + 4'd1);
                    end
                end
            end
            ST_FIN:  if (!i_stat.out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = (r_state == ST_IDLE);
        o_cmd           = '0;
        o_cmd.div_sel   = r_sel;
        o_cmd.accept    = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.calc_ms   = (r_state == ST_MS);
        o_cmd.div_start = (r_state == ST_GO);
        o_cmd.load_out  = (r_state == ST_FIN) && !i_stat.out_busy;
    end

endmodule

// ===== hdl/uccd_datapath.sv =====
// Clock state, millisecond time, constant divider and civil date registers.
module uccd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uccd_pkg::t_dp_cmd i_cmd,
    output uccd_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_secs,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [127:0]      o_m_tdata
);
    import uccd_pkg::*;

    logic [TICK_BITS-1:0] r_tick, r_tick_sync;
    logic [31:0]          r_sync_secs, r_secs;
    logic                 r_sync;
    logic [1:0]           r_op;
    logic [MS_W-1:0]      r_ms, n_ms;

    logic [31:0]          src, r_x, r_recip, r_q, r_r, n_quo, n_rem;
    logic [63:0]          prod;
    logic [DVS_W-1:0]     r_dvs;
    logic [CNT_W-1:0]     r_cnt;
    logic                 ge;
    t_div_sel             r_sel;

    logic [10:0] r_qh;
    logic [9:0]  r_rh;
    logic [31:0] r_ws;
    logic [9:0]  r_milli;
    logic [5:0]  r_sec, r_min;
    logic [4:0]  r_hour;
    logic [26:0] r_t;
    logic [16:0] r_days;
    logic [2:0]  r_era;
    logic [17:0] r_doe;
    logic [6:0]  r_a;
    logic [2:0]  r_b;
    logic [8:0]  r_yoe;
    logic [1:0]  r_y100;
    logic [3:0]  r_mp;
    logic [8:0]  r_dq;

    logic [17:0] x_yoe, doy_w;
    logic [8:0]  doy;
    logic [3:0]  mon;
    logic [4:0]  dy;
    logic [11:0] yr;
    logic        r_out_valid;
    logic [127:0] r_out;

    // state update and millisecond time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_tick_sync <= '0;
            r_sync_secs <= '0;
            r_sync      <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_op == OP_TICK) begin
                r_tick <= r_tick + 1'b1;
            end else if (i_op == OP_SET) begin
                r_sync_secs <= i_secs;
                r_tick_sync <= r_tick;
                r_sync      <= (i_secs != 32'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_secs <= i_secs;
        end
        if (i_cmd.calc_ms) r_ms <= n_ms;
    end

    always_comb begin
        if (r_op == OP_CONVERT) begin
            n_ms = MS_W'(r_secs) * 42'd1000;
        end else if (r_sync) begin
            n_ms = MS_W'(r_sync_secs) * 42'd1000 + MS_W'(r_tick - r_tick_sync);
        end else begin
            n_ms = MS_W'(r_tick);
        end
    end

    // civil-from-days helpers
    always_comb begin
        x_yoe = r_doe - 18'(r_a) + 18'(r_b) - 18'(r_doe == LAST_DOE);
        doy_w = r_doe - 18'(r_yoe) * 18'd365 - 18'(r_yoe[8:2]) + 18'(r_y100);
        doy   = doy_w[8:0];
        dy    = 5'(doy - r_dq + 9'd1);
        mon   = (r_mp < 4'd10) ? (r_mp + 4'd3) : (r_mp - 4'd9);
        yr    = 12'(r_era) * 12'd400 + 12'(r_yoe) + 12'(mon <= 4'd2);
    end

    // time_millis / 1000 runs as two passes: upper 21 bits, then remainder
    // joined with the lower 21 bits
    always_comb begin
        unique case (i_cmd.div_sel)
            DV_MSH:  src = 32'(r_ms[MS_W-1:21]);
            DV_MS:   src = {1'b0, r_rh, r_ms[20:0]};
            DV_SEC:  src = r_ws;
            DV_MIN:  src = 32'(r_t);
            DV_HOUR: src = 32'(r_t);
            DV_ERA:  src = 32'(20'(r_days) + DAYS_OFFSET);
            DV_C4:   src = 32'(r_doe);
            DV_C100: src = 32'(r_doe);
            DV_YOE:  src = 32'(x_yoe);
            DV_Y100: src = 32'(r_yoe);
            DV_MP:   src = 32'(11'(doy) * 11'd5 + 11'd2);
            DV_DAY:  src = 32'(11'(r_mp) * 11'd153 + 11'd2);
            default: src = '0;
        endcase
    end

    // reciprocal estimate, back-multiply, one correction step
    always_comb begin
        prod  = {32'd0, r_x} * {32'd0, r_recip};
        ge    = (r_r >= 32'(r_dvs));
        n_quo = r_q + 32'(ge);
        n_rem = ge ? (r_r - 32'(r_dvs)) : r_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= DIV_STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_x     <= src;
            r_dvs   <= div_divisor(i_cmd.div_sel);
            r_recip <= div_recip(i_cmd.div_sel);
            r_sel   <= i_cmd.div_sel;
        end
        if (r_cnt == DIV_STEPS) r_q <= prod[63:32];
        if (r_cnt == 2'd2) r_r <= r_x - r_q * 32'(r_dvs);
        if (r_cnt == 2'd1) begin
            unique case (r_sel)
                DV_MSH: begin
                    r_qh <= n_quo[10:0];
                    r_rh <= n_rem[9:0];
                end
                DV_MS: begin
                    r_ws    <= {r_qh, n_quo[20:0]};
                    r_milli <= n_rem[9:0];
                end
                DV_SEC: begin
                    r_sec <= n_rem[5:0];
                    r_t   <= n_quo[26:0];
                end
                DV_MIN: begin
                    r_min <= n_rem[5:0];
                    r_t   <= n_quo[26:0];
                end
                DV_HOUR: begin
                    r_hour <= n_rem[4:0];
                    r_days <= n_quo[16:0];
                end
                DV_ERA: begin
                    r_era <= n_quo[2:0];
                    r_doe <= n_rem[17:0];
                end
                DV_C4:   r_a    <= n_quo[6:0];
                DV_C100: r_b    <= n_quo[2:0];
                DV_YOE:  r_yoe  <= n_quo[8:0];
                DV_Y100: r_y100 <= n_quo[1:0];
                DV_MP:   r_mp   <= n_quo[3:0];
                DV_DAY:  r_dq   <= n_quo[8:0];
                default: r_dq   <= r_dq;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= {5'd0, r_sec, r_min, r_hour, dy, mon, yr, r_milli, r_ws, r_ms, r_sync};
        end
    end

    assign o_stat.div_last = (r_cnt == 2'd1);
    assign o_stat.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out;

endmodule
